FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file; they sample on clk and are disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TRD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define TRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/trd_pkg.sv
// Types, codes and helper functions of the TLS record deframer.
`default_nettype none

package trd_pkg;

    localparam int unsigned LEN_W   = 16;
    localparam int unsigned INNER_W = 24;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd16640;

    localparam logic [7:0] TYPE_CCS       = 8'd20;
    localparam logic [7:0] TYPE_ALERT     = 8'd21;
    localparam logic [7:0] TYPE_HANDSHAKE = 8'd22;
    localparam logic [7:0] TYPE_APPDATA   = 8'd23;
    localparam logic [LEN_W-1:0] HS_HDR_LEN = 16'd4;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_HDR2 = 3'd2,
        PH_HDR3 = 3'd3,
        PH_HDR4 = 3'd4,
        PH_BODY = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CCS       = 2'd0,
        KIND_ALERT     = 2'd1,
        KIND_HANDSHAKE = 2'd2,
        KIND_APPDATA   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_COMPLETE = 2'd0,
        ST_BAD_TYPE = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    // Per-direction parse context.
    typedef struct packed {
        phase_t             phase;
        kind_t              kind;
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   seen;
        logic               ccs_pending;
        logic [INNER_W-1:0] inner;
        logic               stuck;
        logic               type_bad;
    } ctx_t;

    localparam ctx_t CTX_RESET = '{
        phase:       PH_HDR0,
        kind:        KIND_CCS,
        len:         '0,
        seen:        '0,
        ccs_pending: 1'b0,
        inner:       '0,
        stuck:       1'b0,
        type_bad:    1'b0
    };

    // One result as produced by the context update.
    typedef struct packed {
        status_t          status;
        kind_t            kind;
        logic [LEN_W-1:0] length;
        logic             accepted;
    } result_t;

    // Pending-CCS flag after a record completes.
    function automatic logic pending_after(input kind_t kind, input logic pending);
        logic p;
        p = pending;
        if (kind == KIND_CCS)
        begin
            p = 1'b1;
        end
        else if (kind == KIND_HANDSHAKE)
        begin
            p = 1'b0;
        end
        return p;
    endfunction

    // Handshake acceptance: after a CCS the inner length must be record length minus 4.
    function automatic logic accept_check(input kind_t kind, input logic pending,
                                          input logic [LEN_W-1:0] len,
                                          input logic [INNER_W-1:0] inner);
        logic             acc;
        logic [LEN_W-1:0] msg_len;
        acc     = 1'b1;
        msg_len = len - HS_HDR_LEN;
        if (kind == KIND_HANDSHAKE && pending)
        begin
            acc = (len >= HS_HDR_LEN) && (inner == {{(INNER_W-LEN_W){1'b0}}, msg_len});
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/trd_if.sv
// Valid/ready stream interfaces for the deframer's byte input and result output.
`default_nettype none

interface trd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       direction;
    logic       flow_start;

    modport source (output valid, output data_byte, output direction, output flow_start,
                    input ready);
    modport sink (input valid, input data_byte, input direction, input flow_start,
                  output ready);
endinterface

interface trd_result_if;
    logic        valid;
    logic        ready;
    logic        result_direction;
    logic [1:0]  status;
    logic [1:0]  record_kind;
    logic [15:0] record_length;
    logic        handshake_accepted;

    modport source (output valid, output result_direction, output status,
                    output record_kind, output record_length, output handshake_accepted,
                    input ready);
    modport sink (input valid, input result_direction, input status,
                  input record_kind, input record_length, input handshake_accepted,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/tls_record_deframer.sv
// Top level of the TLS record-layer deframer.
//
// Takes TCP payload bytes of one flow, one byte per transfer, each tagged with
// its direction, and keeps one record-layer parse context per direction. A
// record is a 5-byte header (content type, two version bytes, big-endian body
// length) and its body. One result transfer comes out when a record's last
// byte arrives (at the fifth header byte for a zero-length record), giving
// kind and length; handshake records after a ChangeCipherSpec, with no
// handshake between, in the same direction are accepted only if body bytes
// 1..3 hold record length minus 4. A content type outside 20..23 or a length
// above max_record_length gives one error result at the fifth header byte,
// after which that direction ignores its bytes until flow_start or reset.
// flow_start on a byte clears both contexts before that byte is parsed.
// Rate: one byte per cycle while no result is held back at the result port. A
// byte passes an input register and then one combinational context update
// into the result register, where its result waits until it is taken.
// Only the result port back-pressures: bytes that produce no result keep
// flowing while a result waits in the output register. The user must write
// max_record_length through cfg_we/cfg_wdata only while the block is idle;
// the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module tls_record_deframer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [trd_pkg::LEN_W-1:0] cfg_wdata,
    trd_byte_if.sink                  bytes,
    trd_result_if.source              results
);

    // Config register
    logic [trd_pkg::LEN_W-1:0] max_len_reg;

    // Input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_dir_reg;
    logic       s1_start_reg;

    // Per-direction contexts
    trd_pkg::ctx_t ctx_reg [2];
    trd_pkg::ctx_t cur_ctx;
    trd_pkg::ctx_t nxt_ctx;

    // Update results
    logic             res_valid;
    trd_pkg::result_t res;

    // Output stage
    logic             out_valid_reg;
    logic             out_dir_reg;
    trd_pkg::result_t out_res_reg;

    logic out_free;
    logic s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= trd_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    // Handshake: the input stage drains when its byte gives no result or the
    // output register is free (empty or being taken this cycle).
    assign out_free    = !out_valid_reg || results.ready;
    assign s1_advance  = s1_valid_reg && (!res_valid || out_free);
    assign bytes.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            s1_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            s1_byte_reg  <= bytes.data_byte;
            s1_dir_reg   <= bytes.direction;
            s1_start_reg <= bytes.flow_start;
        end
    end

    // flow_start wipes the context before the byte is parsed
    assign cur_ctx = s1_start_reg ? trd_pkg::CTX_RESET : ctx_reg[s1_dir_reg];

    trd_ctx_update u_update (
        .cur       (cur_ctx),
        .data_byte (s1_byte_reg),
        .max_len   (max_len_reg),
        .nxt       (nxt_ctx),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg[0] <= trd_pkg::CTX_RESET;
            ctx_reg[1] <= trd_pkg::CTX_RESET;
        end
        else if (s1_advance)
        begin
            for (int d = 0; d < 2; d++)
            begin
                if (s1_dir_reg == d[0])
                begin
                    ctx_reg[d] <= nxt_ctx;
                end
                else if (s1_start_reg)
                begin
                    ctx_reg[d] <= trd_pkg::CTX_RESET;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && res_valid)
        begin
            out_dir_reg <= s1_dir_reg;
            out_res_reg <= res;
        end
    end

    assign results.valid              = out_valid_reg;
    assign results.result_direction   = out_dir_reg;
    assign results.status             = out_res_reg.status;
    assign results.record_kind        = out_res_reg.kind;
    assign results.record_length      = out_res_reg.length;
    assign results.handshake_accepted = out_res_reg.accepted;

    // A direction only gets stuck together with an error result.
    `TRD_ASSERT_SAME(a_stuck_fwd_err, $rose(ctx_reg[0].stuck),
        out_valid_reg && !out_dir_reg && out_res_reg.status != trd_pkg::ST_COMPLETE)
    `TRD_ASSERT_SAME(a_stuck_rev_err, $rose(ctx_reg[1].stuck),
        out_valid_reg && out_dir_reg && out_res_reg.status != trd_pkg::ST_COMPLETE)
    // In the forward direction's body the byte count stays below the record length.
    `TRD_ASSERT_SAME(a_body_count_fwd, ctx_reg[0].phase == trd_pkg::PH_BODY,
        ctx_reg[0].seen < ctx_reg[0].len)
    // A byte held back by a full output register stays in the input stage.
    `TRD_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_advance,
        s1_valid_reg && $stable(s1_byte_reg) && $stable(s1_dir_reg))

endmodule

`default_nettype wire

FILE: hdl/trd_ctx_update.sv
// Combinational record-layer parse step: one byte against one direction's context.
`default_nettype none

module trd_ctx_update (
    input  trd_pkg::ctx_t                  cur,
    input  logic [7:0]                     data_byte,
    input  logic [trd_pkg::LEN_W-1:0]      max_len,
    output trd_pkg::ctx_t                  nxt,
    output logic                           res_valid,
    output trd_pkg::result_t               res
);

    logic [trd_pkg::LEN_W-1:0]   len_full;
    logic [trd_pkg::LEN_W-1:0]   seen_inc;
    logic [trd_pkg::INNER_W-1:0] inner_shift;
    logic                        in_inner;
    logic                        byte_bad;

    assign len_full    = {cur.len[trd_pkg::LEN_W-1:8], data_byte};
    assign seen_inc    = cur.seen + 16'd1;
    assign in_inner    = (cur.seen >= 16'd1) && (cur.seen <= 16'd3);
    assign inner_shift = in_inner ? {cur.inner[trd_pkg::INNER_W-9:0], data_byte} : cur.inner;
    assign byte_bad    = (data_byte < trd_pkg::TYPE_CCS) || (data_byte > trd_pkg::TYPE_APPDATA);

    // Next context
    always_comb
    begin
        nxt = cur;
        if (!cur.stuck)
        begin
            unique case (cur.phase)
                trd_pkg::PH_HDR1: nxt.phase = trd_pkg::PH_HDR2;
                trd_pkg::PH_HDR2: nxt.phase = trd_pkg::PH_HDR3;
                trd_pkg::PH_HDR3:
                begin
                    nxt.len   = {data_byte, 8'h00};
                    nxt.phase = trd_pkg::PH_HDR4;
                end
                trd_pkg::PH_HDR4:
                begin
                    nxt.len = len_full;
                    if (cur.type_bad || (len_full > max_len))
                    begin
                        nxt.stuck = 1'b1;
                    end
                    else
                    begin
                        nxt.seen  = '0;
                        nxt.inner = '0;
                        if (len_full == '0)
                        begin
                            nxt.ccs_pending = trd_pkg::pending_after(cur.kind, cur.ccs_pending);
                            nxt.phase       = trd_pkg::PH_HDR0;
                        end
                        else
                        begin
                            nxt.phase = trd_pkg::PH_BODY;
                        end
                    end
                end
                trd_pkg::PH_BODY:
                begin
                    nxt.inner = inner_shift;
                    nxt.seen  = seen_inc;
                    if (seen_inc == cur.len)
                    begin
                        nxt.ccs_pending = trd_pkg::pending_after(cur.kind, cur.ccs_pending);
                        nxt.phase       = trd_pkg::PH_HDR0;
                    end
                end
                default:
                begin
                    // header byte zero; unused phase codes land here too
                    nxt.type_bad = byte_bad;
                    nxt.kind     = byte_bad ? trd_pkg::KIND_CCS
                                            : trd_pkg::kind_t'(data_byte[1:0]);
                    nxt.phase    = trd_pkg::PH_HDR1;
                end
            endcase
        end
    end

    // Result
    always_comb
    begin
        res_valid    = 1'b0;
        res.status   = trd_pkg::ST_COMPLETE;
        res.kind     = cur.kind;
        res.length   = cur.len;
        res.accepted = 1'b1;
        if (!cur.stuck)
        begin
            unique case (cur.phase)
                trd_pkg::PH_HDR4:
                begin
                    res.length = len_full;
                    if (cur.type_bad)
                    begin
                        res_valid  = 1'b1;
                        res.status = trd_pkg::ST_BAD_TYPE;
                        res.kind   = trd_pkg::KIND_CCS;
                    end
                    else if (len_full > max_len)
                    begin
                        res_valid  = 1'b1;
                        res.status = trd_pkg::ST_TOO_LONG;
                    end
                    else if (len_full == '0)
                    begin
                        res_valid    = 1'b1;
                        res.accepted = trd_pkg::accept_check(cur.kind, cur.ccs_pending,
                                                             len_full, '0);
                    end
                end
                trd_pkg::PH_BODY:
                begin
                    if (seen_inc == cur.len)
                    begin
                        res_valid    = 1'b1;
                        res.accepted = trd_pkg::accept_check(cur.kind, cur.ccs_pending,
                                                             cur.len, inner_shift);
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: tb/tls_record_deframer_tb.sv
// Self-checking testbench for the TLS record deframer: directed table, then random byte streams.
`timescale 1ns / 100ps

module tls_record_deframer_tb;

    // One record report as it leaves the result port.
    typedef struct packed {
        logic                      dir;
        trd_pkg::status_t          status;
        trd_pkg::kind_t            kind;
        logic [trd_pkg::LEN_W-1:0] len;
        logic                      acc;
    } rec_result_t;

    // Per-direction parse state kept by the predictor.
    typedef struct packed {
        trd_pkg::phase_t             phase;
        trd_pkg::kind_t              kind;
        logic [trd_pkg::LEN_W-1:0]   len;
        logic [trd_pkg::LEN_W-1:0]   seen;
        logic                        pend;
        logic [trd_pkg::INNER_W-1:0] inner;
        logic                        stuck;
        logic                        bad;
    } flow_ctx_t;

    // Directed row: the byte, its tags, and an optional hand-written result.
    typedef struct packed {
        logic [7:0]  b;
        logic        d;
        logic        fs;
        logic        typed;
        logic        has;
        rec_result_t r;
    } stim_row_t;

    localparam rec_result_t NO_RES = '0;
    localparam int N_ROWS = 27;

    // Directed part. Typed rows carry their result; the rest go through the predictor.
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        // forward CCS with zero length, flow_start on its first byte: done at header byte 5
        '{8'h14, 1'b0, 1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1,
          '{1'b0, trd_pkg::ST_COMPLETE, trd_pkg::KIND_CCS, 16'd0, 1'b1}},
        // reverse bad content type, all-ones length
        '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1,
          '{1'b1, trd_pkg::ST_BAD_TYPE, trd_pkg::KIND_CCS, 16'hFFFF, 1'b1}},
        // forward zero-length handshake right after the CCS: too short, rejected
        '{8'h16, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1,
          '{1'b0, trd_pkg::ST_COMPLETE, trd_pkg::KIND_HANDSHAKE, 16'd0, 1'b0}},
        // reverse is stuck: this byte is dropped
        '{8'h16, 1'b1, 1'b0, 1'b1, 1'b0, NO_RES},
        // forward app data one above the reset limit
        '{8'h17, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h41, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, 1'b1, 1'b1,
          '{1'b0, trd_pkg::ST_TOO_LONG, trd_pkg::KIND_APPDATA, 16'h4101, 1'b1}},
        // flow_start unsticks both; reverse alert with a one-byte body
        '{8'h15, 1'b1, 1'b1, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
        '{8'h02, 1'b1, 1'b0, 1'b0, 1'b0, NO_RES}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [trd_pkg::LEN_W-1:0] cfg_wdata;

    trd_byte_if   byte_ch ();
    trd_result_if res_ch ();

    tls_record_deframer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .bytes     (byte_ch),
        .results   (res_ch)
    );

    // Predictor state and its copy of the length limit.
    flow_ctx_t                 dir_ctx [2];
    logic [trd_pkg::LEN_W-1:0] max_len;

    // Reports still owed by the block, oldest first.
    rec_result_t due_reports [$];

    // Random stream generator: bytes queued per direction.
    logic [7:0] gen_q0 [$];
    logic [7:0] gen_q1 [$];
    logic [7:0] record_buf [$];
    logic [1:0] gen_stuck;
    logic       force_fs;

    int src_idle_pct;
    int snk_idle_pct;
    int error_count;
    int bytes_sent;
    int bytes_ignored;
    int limits_used;
    int n_complete;
    int n_bad_type;
    int n_too_long;
    int n_hs_rejected;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #2000000;
        $display("%0t: timeout, %0d reports still owed", $time, due_reports.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Append one byte to the record under construction.
    function automatic void buf_add(input logic [7:0] b);
        record_buf = {record_buf, b};
    endfunction

    // Finish a record: updates the pending-CCS flag and judges handshakes.
    function automatic rec_result_t close_record(input logic d);
        rec_result_t r;
        logic        acc;
        acc = 1'b1;
        if (dir_ctx[d].kind == trd_pkg::KIND_CCS)
        begin
            dir_ctx[d].pend = 1'b1;
        end
        else if (dir_ctx[d].kind == trd_pkg::KIND_HANDSHAKE && dir_ctx[d].pend)
        begin
            acc = (dir_ctx[d].len >= trd_pkg::HS_HDR_LEN) &&
                  (dir_ctx[d].inner == {8'h00, dir_ctx[d].len - trd_pkg::HS_HDR_LEN});
            dir_ctx[d].pend = 1'b0;
        end
        r = '{d, trd_pkg::ST_COMPLETE, dir_ctx[d].kind, dir_ctx[d].len, acc};
        dir_ctx[d].phase = trd_pkg::PH_HDR0;
        return r;
    endfunction

    // Predict the effect of one accepted byte.
    function automatic void parse_byte(input logic [7:0] b, input logic d, input logic fs,
                                       output logic has, output rec_result_t r);
        logic [7:0] off;
        has = 1'b0;
        r   = NO_RES;
        off = b - trd_pkg::TYPE_CCS;
        if (fs)
        begin
            dir_ctx[0] = '0;
            dir_ctx[1] = '0;
        end
        if (dir_ctx[d].stuck)
        begin
            bytes_ignored++;
            return;
        end
        case (dir_ctx[d].phase)
            trd_pkg::PH_HDR1:
            begin
                dir_ctx[d].phase = trd_pkg::PH_HDR2;
            end
            trd_pkg::PH_HDR2:
            begin
                dir_ctx[d].phase = trd_pkg::PH_HDR3;
            end
            trd_pkg::PH_HDR3:
            begin
                dir_ctx[d].len   = {b, 8'h00};
                dir_ctx[d].phase = trd_pkg::PH_HDR4;
            end
            trd_pkg::PH_HDR4:
            begin
                dir_ctx[d].len = {dir_ctx[d].len[15:8], b};
                if (dir_ctx[d].bad)
                begin
                    dir_ctx[d].stuck = 1'b1;
                    has = 1'b1;
                    r   = '{d, trd_pkg::ST_BAD_TYPE, trd_pkg::KIND_CCS, dir_ctx[d].len, 1'b1};
                end
                else if (dir_ctx[d].len > max_len)
                begin
                    dir_ctx[d].stuck = 1'b1;
                    has = 1'b1;
                    r   = '{d, trd_pkg::ST_TOO_LONG, dir_ctx[d].kind, dir_ctx[d].len, 1'b1};
                end
                else
                begin
                    dir_ctx[d].seen  = '0;
                    dir_ctx[d].inner = '0;
                    if (dir_ctx[d].len == 16'd0)
                    begin
                        has = 1'b1;
                        r   = close_record(d);
                    end
                    else
                    begin
                        dir_ctx[d].phase = trd_pkg::PH_BODY;
                    end
                end
            end
            trd_pkg::PH_BODY:
            begin
                // handshake length sits in body bytes 1..3
                if (dir_ctx[d].seen >= 16'd1 && dir_ctx[d].seen <= 16'd3)
                begin
                    dir_ctx[d].inner = {dir_ctx[d].inner[15:0], b};
                end
                dir_ctx[d].seen = dir_ctx[d].seen + 16'd1;
                if (dir_ctx[d].seen == dir_ctx[d].len)
                begin
                    has = 1'b1;
                    r   = close_record(d);
                end
            end
            default:
            begin
                dir_ctx[d].bad   = (b < trd_pkg::TYPE_CCS) || (b > trd_pkg::TYPE_APPDATA);
                dir_ctx[d].kind  = dir_ctx[d].bad ? trd_pkg::KIND_CCS
                                                  : trd_pkg::kind_t'(off[1:0]);
                dir_ctx[d].phase = trd_pkg::PH_HDR1;
            end
        endcase
    endfunction

    // Offer one byte, wait for its transfer, then predict.
    task automatic send_byte(input logic [7:0] b, input logic d, input logic fs,
                             input logic typed, input logic typed_has,
                             input rec_result_t typed_res);
        logic        has;
        rec_result_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= b;
        byte_ch.direction  <= d;
        byte_ch.flow_start <= fs;
        @(posedge clk);
        while (!byte_ch.ready)
        begin
            @(posedge clk);
        end
        parse_byte(b, d, fs, has, r);
        if (typed)
        begin
            has = typed_has;
            r   = typed_res;
        end
        if (has)
        begin
            due_reports = {due_reports, r};
        end
        bytes_sent++;
    endtask

    // Let owed reports drain, then wait for bytes still in the pipe.
    task automatic wait_drained();
        int n;
        n = 0;
        while (due_reports.size() != 0 && n < 50000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
    endtask

    // Next chunk of stream for one direction into record_buf.
    task automatic build_record(input logic d);
        int         sel;
        int         lim;
        int         cap;
        int         len;
        int         i;
        logic [7:0] t;
        logic       good_inner;
        logic [23:0] inner;
        record_buf.delete();
        sel = $urandom_range(99);
        if (gen_stuck[d])
        begin
            // direction is dead; this byte should be dropped
            buf_add(8'($urandom_range(255)));
        end
        else if (sel < 80)
        begin
            // well-formed record, kind weighted toward CCS, handshake and app data
            sel = $urandom_range(9);
            t = (sel < 3) ? trd_pkg::TYPE_CCS :
                (sel < 4) ? trd_pkg::TYPE_ALERT :
                (sel < 7) ? trd_pkg::TYPE_HANDSHAKE : trd_pkg::TYPE_APPDATA;
            sel = $urandom_range(99);
            lim = (sel < 85) ? 16 : (sel < 97) ? 48 : 300;
            cap = (max_len < lim) ? int'(max_len) : lim;
            if (cap == 0 || sel < 8)
            begin
                len = 0;
            end
            else if (sel == 99)
            begin
                len = cap;
            end
            else
            begin
                len = $urandom_range(cap, 1);
            end
            buf_add(t);
            buf_add(8'($urandom_range(255)));
            buf_add(8'($urandom_range(255)));
            buf_add(8'(len >> 8));
            buf_add(8'(len));
            good_inner = (t == trd_pkg::TYPE_HANDSHAKE) && (len >= 4) &&
                         ($urandom_range(3) != 0);
            inner = 24'(len - 4);
            for (i = 0; i < len; i++)
            begin
                if (good_inner && i >= 1 && i <= 3)
                begin
                    buf_add(inner[8*(3-i) +: 8]);
                end
                else
                begin
                    buf_add(8'($urandom_range(255)));
                end
            end
        end
        else if (sel < 90)
        begin
            // header that must stick the direction
            if ($urandom_range(1) == 0 || max_len == 16'hFFFF)
            begin
                t = 8'($urandom_range(255));
                if (t >= trd_pkg::TYPE_CCS && t <= trd_pkg::TYPE_APPDATA)
                begin
                    t = t ^ 8'h80;
                end
                len = $urandom_range(65535);
            end
            else
            begin
                t   = trd_pkg::TYPE_CCS + 8'($urandom_range(3));
                len = ($urandom_range(1) == 0) ? int'(max_len) + 1
                                               : $urandom_range(65535, int'(max_len) + 1);
            end
            buf_add(t);
            buf_add(8'($urandom_range(255)));
            buf_add(8'($urandom_range(255)));
            buf_add(8'(len >> 8));
            buf_add(8'(len));
            gen_stuck[d] = 1'b1;
        end
        else
        begin
            // junk or a cut-off record; a flow_start resyncs afterwards
            lim = $urandom_range(12, 1);
            for (i = 0; i < lim; i++)
            begin
                buf_add(8'($urandom_range(255)));
            end
            force_fs = 1'b1;
        end
    endtask

    // One random phase: new length limit, idle pattern, then count live bytes.
    task automatic run_phase(input logic [trd_pkg::LEN_W-1:0] limit, input int src_pct,
                             input int snk_pct, input int count);
        int         base;
        int         i;
        logic       d;
        logic       fs;
        logic [7:0] b;
        // block is idle here: write the register
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_we  <= 1'b0;
        max_len = limit;
        limits_used++;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        // start from clean contexts so the generator stays aligned
        gen_q0.delete();
        gen_q1.delete();
        gen_stuck = '0;
        force_fs  = 1'b1;
        base = bytes_sent - bytes_ignored;
        while (bytes_sent - bytes_ignored - base < count)
        begin
            d  = 1'($urandom_range(1));
            fs = 1'b0;
            if ((d ? gen_q1.size() : gen_q0.size()) == 0)
            begin
                if (force_fs || (gen_stuck[d] && $urandom_range(2) != 0) ||
                    $urandom_range(199) == 0)
                begin
                    gen_q0.delete();
                    gen_q1.delete();
                    gen_stuck = '0;
                    force_fs  = 1'b0;
                    fs        = 1'b1;
                end
                build_record(d);
                if (d)
                    gen_q1 = {gen_q1, record_buf};
                else
                    gen_q0 = {gen_q0, record_buf};
            end
            b = d ? gen_q1.pop_front() : gen_q0.pop_front();
            send_byte(b, d, fs, 1'b0, 1'b0, NO_RES);
        end
        byte_ch.valid <= 1'b0;
        wait_drained();
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            if (error_count < 40)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
            error_count++;
        end
    endtask

    // Result side: random back-pressure and the per-field check of each transfer.
    initial
    begin : result_side
        rec_result_t want;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                case (res_ch.status)
                    trd_pkg::ST_COMPLETE: n_complete++;
                    trd_pkg::ST_BAD_TYPE: n_bad_type++;
                    default:              n_too_long++;
                endcase
                if (res_ch.record_kind == trd_pkg::KIND_HANDSHAKE &&
                    !res_ch.handshake_accepted)
                begin
                    n_hs_rejected++;
                end
                if (due_reports.size() == 0)
                begin
                    if (error_count < 40)
                    begin
                        $display({"%0t: unexpected result, expected none, actual dir %0d ",
                                  "status %0d kind %0d length %0d accepted %0d"},
                                 $time, res_ch.result_direction,
                                 res_ch.status, res_ch.record_kind, res_ch.record_length,
                                 res_ch.handshake_accepted);
                    end
                    error_count++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    report_field("result_direction", want.dir, res_ch.result_direction);
                    report_field("status", want.status, res_ch.status);
                    report_field("record_kind", want.kind, res_ch.record_kind);
                    report_field("record_length", want.len, res_ch.record_length);
                    report_field("handshake_accepted", want.acc, res_ch.handshake_accepted);
                end
            end
            res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Main sequence: reset, directed table, four random phases, final drain.
    initial
    begin : main_seq
        int i;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        byte_ch.valid      <= 1'b0;
        byte_ch.data_byte  <= 8'h00;
        byte_ch.direction  <= 1'b0;
        byte_ch.flow_start <= 1'b0;
        dir_ctx[0]    = '0;
        dir_ctx[1]    = '0;
        max_len       = trd_pkg::MAX_LEN_RESET;
        gen_stuck     = '0;
        force_fs      = 1'b0;
        src_idle_pct  = 16;
        snk_idle_pct  = 63;
        error_count   = 0;
        bytes_sent    = 0;
        bytes_ignored = 0;
        limits_used   = 0;
        n_complete    = 0;
        n_bad_type    = 0;
        n_too_long    = 0;
        n_hs_rejected = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs with the reset limit
        for (i = 0; i < N_ROWS; i++)
        begin
            send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].d, DIRECTED_ROWS[i].fs,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].has, DIRECTED_ROWS[i].r);
        end
        byte_ch.valid <= 1'b0;
        wait_drained();

        // sender sparse idles, receiver heavy stalls, twice; then swapped; then full rate
        run_phase(16'd40,    16, 63, 500);
        run_phase(16'd0,     16, 63, 150);
        run_phase(16'hFFFF,  63, 16, 500);
        run_phase(16'd300,    0,  0, 500);

        if (due_reports.size() != 0)
        begin
            $display("%0t: reports never seen, expected %0d more, actual 0",
                     $time, due_reports.size());
            error_count += due_reports.size();
        end
        $display("Covered %0d bytes (%0d dropped on stuck directions) under %0d length limits.",
                 bytes_sent, bytes_ignored, limits_used + 1);
        $display("Results: %0d complete, %0d bad type, %0d too long, %0d handshakes rejected.",
                 n_complete, n_bad_type, n_too_long, n_hs_rejected);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
